/* hdl/ask_pkg.sv */
// ----------------------------------------------------------------------------
// ask_pkg
// Shared widths, register codes, command record and arctangent table for
// the ackermann steering kinematics block.
// ----------------------------------------------------------------------------
package ask_pkg;

    localparam int CFG_IDX_W    = 3;
    localparam int LEN_W        = 16;
    localparam int IN_W         = 16;
    localparam int YW           = 33;
    localparam int XW           = 35;
    localparam int NUMW         = 61;
    localparam int DENW         = 49;
    localparam int ANG_W        = 15;
    localparam int RATE_W       = 24;
    localparam int CW           = 44;
    localparam int ZW           = 22;
    localparam int NORM_W       = 41;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_IW      = $clog2(CORDIC_STEPS);
    localparam int QBITS        = 25;
    localparam int COR_LAT      = CORDIC_STEPS + 4;
    localparam int DIV_LAT      = QBITS + 3;
    localparam int FRONT_STAGES = 5;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic signed [ANG_W-1:0] HALF_PI = 15'sd12868;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXLE_BASE       = 3'd0,
        REG_MIN_TURN_RADIUS = 3'd1,
        REG_WHEEL_TRACK     = 3'd2,
        REG_KINGPIN_SPAN    = 3'd3,
        REG_TYRE_RADIUS     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] axle_base;
        logic [LEN_W-1:0] min_turn_radius;
        logic [LEN_W-1:0] wheel_track;
        logic [LEN_W-1:0] kingpin_span;
        logic [LEN_W-1:0] tyre_radius;
    } t_geom;

    typedef struct packed {
        logic                    straight;
        logic [YW-1:0]           y;
        logic signed [XW-1:0]    xl;
        logic signed [XW-1:0]    xr;
        logic signed [NUMW-1:0]  numl;
        logic signed [NUMW-1:0]  numr;
        logic signed [DENW-1:0]  den;
    } t_cmd;

    // atan(2^-i) in units of 2^-20 rad
    function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_IW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 22'sd823550;
            5'd1:    v = 22'sd486170;
            5'd2:    v = 22'sd256879;
            5'd3:    v = 22'sd130396;
            5'd4:    v = 22'sd65451;
            5'd5:    v = 22'sd32757;
            5'd6:    v = 22'sd16383;
            5'd7:    v = 22'sd8192;
            5'd8:    v = 22'sd4096;
            5'd9:    v = 22'sd2048;
            5'd10:   v = 22'sd1024;
            5'd11:   v = 22'sd512;
            5'd12:   v = 22'sd256;
            5'd13:   v = 22'sd128;
            5'd14:   v = 22'sd64;
            5'd15:   v = 22'sd32;
            5'd16:   v = 22'sd16;
            5'd17:   v = 22'sd8;
            5'd18:   v = 22'sd4;
            5'd19:   v = 22'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/ackermann_steering_kinematics.sv */
// ----------------------------------------------------------------------------
// ackermann_steering_kinematics
// Each command passes through the front pipe, the queue and the divider lanes,
// in that order, from input transfer to result.
// Throughput: one command per cycle while the receiver does not stall, set by
// the fully pipelined arctangent and divider lanes.
// Reset clears the pipes and queue and loads the default geometry.
// ----------------------------------------------------------------------------
module ackermann_steering_kinematics import ask_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // forward_speed, yaw_rate
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [79:0]          m_axis_tdata,   // left_steer_angle, right_steer_angle,
                                                 // left_wheel_rate, right_wheel_rate
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    t_geom r_geom;
    t_cmd  f_cmd, q_cmd;
    logic  f_push, q_full, q_empty, b_pop;
    logic signed [ANG_W-1:0]  ang_l, ang_r;
    logic signed [RATE_W-1:0] rate_l, rate_r;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.axle_base       <= LEN_W'(2560);
            r_geom.min_turn_radius <= LEN_W'(5120);
            r_geom.wheel_track     <= LEN_W'(1536);
            r_geom.kingpin_span    <= LEN_W'(1229);
            r_geom.tyre_radius     <= LEN_W'(307);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AXLE_BASE:       r_geom.axle_base       <= i_cfg_data;
                REG_MIN_TURN_RADIUS: r_geom.min_turn_radius <= i_cfg_data;
                REG_WHEEL_TRACK:     r_geom.wheel_track     <= i_cfg_data;
                REG_KINGPIN_SPAN:    r_geom.kingpin_span    <= i_cfg_data;
                REG_TYRE_RADIUS:     r_geom.tyre_radius     <= i_cfg_data;
                default:             r_geom                 <= r_geom;
            endcase
        end
    end

    ask_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_speed  (signed'(s_axis_tdata[15:0])),
        .i_yaw    (signed'(s_axis_tdata[31:16])),
        .i_geom   (r_geom),
        .i_q_full (q_full),
        .o_push   (f_push),
        .o_cmd    (f_cmd)
    );

    ask_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    ask_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .o_pop         (b_pop),
        .i_cmd         (q_cmd),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_left_angle  (ang_l),
        .o_right_angle (ang_r),
        .o_left_rate   (rate_l),
        .o_right_rate  (rate_r)
    );

    assign m_axis_tdata = {2'b00, rate_r, rate_l, ang_r, ang_l};

endmodule

/* hdl/ask_front.sv */
// ----------------------------------------------------------------------------
// ask_front
// Accepts commands, classifies them as straight, clamped or free turns and
// builds the arctangent operands and the wheel rate fractions.
// ----------------------------------------------------------------------------
module ask_front import ask_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IN_W-1:0] i_speed,
    input  logic signed [IN_W-1:0] i_yaw,
    input  t_geom                  i_geom,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic                    en;
    logic [FRONT_STAGES-1:0] r_v;

    // stage 1
    logic [IN_W:0]   sx, wx;
    logic [IN_W-1:0] n_as, n_aw;
    logic [17:0]     n_lim2;
    logic [IN_W-1:0] r1_as, r1_aw;
    logic            r1_sneg, r1_wneg;
    logic signed [IN_W-1:0] r1_s;
    logic [31:0]     r1_awlb;
    logic [33:0]     r1_awlim;
    logic [17:0]     r1_lim2;

    // stage 2
    logic [51:0]     n_big;
    logic            n_straight, n_clamp, n_pos;
    logic [30:0]     n_mag;
    logic signed [30:0] n_rn;
    logic            r2_straight;
    logic signed [30:0] r2_rn;
    logic [LEN_W-1:0] r2_rd;
    logic signed [IN_W-1:0] r2_s;

    // stage 3
    logic [31:0]     r3_kprd, r3_trkrd, r3_lbrd;
    logic signed [47:0] r3_rntr;
    logic signed [30:0] r3_rn;
    logic            r3_straight;
    logic signed [IN_W-1:0] r3_s;

    // stage 4
    logic signed [XW-1:0] n_rn2;
    logic signed [XW-1:0] r4_xl, r4_xr, r4_ml, r4_mr;
    logic [YW-1:0]        r4_y;
    logic signed [DENW-1:0] r4_den;
    logic                 r4_straight, r4_plain;
    logic signed [IN_W-1:0] r4_s;

    t_cmd r5_cmd;

    assign en      = !r_v[FRONT_STAGES-1] || !i_q_full;
    assign o_ready = en;
    assign o_push  = r_v[FRONT_STAGES-1] && !i_q_full;
    assign o_cmd   = r5_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_comb begin
        sx     = {i_speed[IN_W-1], i_speed};
        wx     = {i_yaw[IN_W-1], i_yaw};
        n_as   = sx[IN_W] ? IN_W'(~sx + 1'b1) : sx[IN_W-1:0];
        n_aw   = wx[IN_W] ? IN_W'(~wx + 1'b1) : wx[IN_W-1:0];
        n_lim2 = {1'b0, i_geom.min_turn_radius, 1'b0} + {2'b00, i_geom.wheel_track};
    end

    always_comb begin
        n_big      = 52'(r1_awlb) * 52'(20'd1000000);
        n_straight = (r1_as == '0) || (n_big < (52'(r1_as) << 14));
        n_clamp    = r1_awlim > (34'(r1_as) << 15);
        n_pos      = (r1_sneg == r1_wneg);
        n_mag      = n_clamp ? 31'(r1_lim2) : (31'(r1_as) << 14);
        n_rn       = n_pos ? signed'(n_mag) : -signed'(n_mag);
        n_rn2      = XW'(r3_rn) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_as    <= n_as;
            r1_aw    <= n_aw;
            r1_sneg  <= i_speed[IN_W-1];
            r1_wneg  <= i_yaw[IN_W-1];
            r1_s     <= i_speed;
            r1_awlb  <= 32'(n_aw) * 32'(i_geom.axle_base);
            r1_awlim <= 34'(n_aw) * 34'(n_lim2);
            r1_lim2  <= n_lim2;

            r2_straight <= n_straight;
            r2_rn       <= n_rn;
            r2_rd       <= n_clamp ? LEN_W'(2) : r1_aw;
            r2_s        <= r1_s;

            r3_kprd     <= 32'(i_geom.kingpin_span) * 32'(r2_rd);
            r3_trkrd    <= 32'(i_geom.wheel_track) * 32'(r2_rd);
            r3_lbrd     <= 32'(i_geom.axle_base) * 32'(r2_rd);
            r3_rntr     <= 48'(r2_rn) * 48'(signed'({1'b0, i_geom.tyre_radius}));
            r3_rn       <= r2_rn;
            r3_straight <= r2_straight;
            r3_s        <= r2_s;

            r4_xl       <= n_rn2 - XW'(signed'({1'b0, r3_kprd}));
            r4_xr       <= n_rn2 + XW'(signed'({1'b0, r3_kprd}));
            r4_ml       <= n_rn2 - XW'(signed'({1'b0, r3_trkrd}));
            r4_mr       <= n_rn2 + XW'(signed'({1'b0, r3_trkrd}));
            r4_y        <= YW'({r3_lbrd, 1'b0});
            r4_straight <= r3_straight;
            // zero turn radius falls back to the straight wheel rate
            r4_plain    <= r3_straight || (r3_rn == '0);
            r4_den      <= (r3_straight || (r3_rn == '0))
                           ? DENW'(signed'({1'b0, i_geom.tyre_radius}))
                           : (DENW'(r3_rntr) <<< 1);
            r4_s        <= r3_s;

            r5_cmd.straight <= r4_straight;
            r5_cmd.y        <= r4_y;
            r5_cmd.xl       <= r4_xl;
            r5_cmd.xr       <= r4_xr;
            r5_cmd.den      <= r4_den;
            r5_cmd.numl     <= r4_plain ? (NUMW'(r4_s) <<< 10)
                                        : ((NUMW'(r4_s) * NUMW'(r4_ml)) <<< 10);
            r5_cmd.numr     <= r4_plain ? (NUMW'(r4_s) <<< 10)
                                        : ((NUMW'(r4_s) * NUMW'(r4_mr)) <<< 10);
        end
    end

endmodule

/* hdl/ask_fifo.sv */
// ----------------------------------------------------------------------------
// ask_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ask_fifo import ask_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/ask_cordic.sv */
// ----------------------------------------------------------------------------
// ask_cordic
// Pipelined vectoring arctangent: normalize, twenty rotation stages, round.
// ----------------------------------------------------------------------------
module ask_cordic import ask_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_force_zero,
    input  logic [YW-1:0]           i_y,
    input  logic signed [XW-1:0]    i_x,
    output logic signed [ANG_W-1:0] o_angle
);

    localparam int FLN = CORDIC_STEPS + 3;

    typedef struct packed {
        logic [NORM_W-1:0] x;
        logic [NORM_W-1:0] y;
        logic [NORM_W-1:0] m;
    } t_vec;

    typedef struct packed {
        logic force_zero;
        logic xzero;
        logic xneg;
    } t_cflag;

    function automatic t_vec nstep(input t_vec v, input int unsigned k);
        t_vec r;
        r = v;
        // shift up by k if the top k bits are clear
        if ((v.m >> (NORM_W - k)) == '0) begin
            r.x = v.x << k;
            r.y = v.y << k;
            r.m = v.m << k;
        end
        return r;
    endfunction

    logic [XW-1:0]      n_xa;
    t_vec               n_a;
    t_vec               r_a, r_b, r_c;
    t_cflag             r_fl [FLN];
    logic signed [ZW-1:0] n_sum;
    logic [ANG_W-1:0]   n_r;
    logic signed [ANG_W-1:0] n_ang;
    logic signed [ANG_W-1:0] r_ang;

    wire logic signed [CW-1:0] w_xs [CORDIC_STEPS+1];
    wire logic signed [CW-1:0] w_ys [CORDIC_STEPS+1];
    wire logic signed [ZW-1:0] w_z  [CORDIC_STEPS+1];

    always_comb begin
        n_xa  = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
        n_a.x = NORM_W'(n_xa);
        n_a.y = NORM_W'(i_y);
        n_a.m = (NORM_W'(n_xa) > NORM_W'(i_y)) ? NORM_W'(n_xa) : NORM_W'(i_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= nstep(nstep(nstep(r_a, 32), 16), 8);
            r_c <= nstep(nstep(nstep(r_b, 4), 2), 1);
            r_fl[0] <= '{force_zero: i_force_zero, xzero: (i_x == '0), xneg: i_x[XW-1]};
            for (int i = 1; i < FLN; i++) begin
                r_fl[i] <= r_fl[i-1];
            end
        end
    end

    assign w_xs[0] = CW'(r_c.x);
    assign w_ys[0] = CW'(r_c.y);
    assign w_z[0]  = '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
        logic signed [CW-1:0] r_xs, r_ys;
        logic signed [ZW-1:0] r_z;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_ys[g][CW-1] && (w_ys[g] != '0)) begin
                    r_xs <= w_xs[g] + (w_ys[g] >>> g);
                    r_ys <= w_ys[g] - (w_xs[g] >>> g);
                    r_z  <= w_z[g] + atan_step(STEP_IW'(g));
                end else begin
                    r_xs <= w_xs[g] - (w_ys[g] >>> g);
                    r_ys <= w_ys[g] + (w_xs[g] >>> g);
                    r_z  <= w_z[g] - atan_step(STEP_IW'(g));
                end
            end
        end
        assign w_xs[g+1] = r_xs;
        assign w_ys[g+1] = r_ys;
        assign w_z[g+1]  = r_z;
    end

    always_comb begin
        n_sum = w_z[CORDIC_STEPS] + ZW'(64);
        n_r   = n_sum[ANG_W+6:7];
        if (n_r > ANG_W'(HALF_PI)) begin
            n_r = ANG_W'(HALF_PI);
        end
        if (w_z[CORDIC_STEPS][ZW-1]) begin
            n_r = '0;
        end
        if (r_fl[FLN-1].force_zero) begin
            n_ang = '0;
        end else if (r_fl[FLN-1].xzero) begin
            n_ang = HALF_PI;
        end else if (r_fl[FLN-1].xneg) begin
            n_ang = -signed'(n_r);
        end else begin
            n_ang = signed'(n_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    assign o_angle = r_ang;

endmodule

/* hdl/ask_div.sv */
// ----------------------------------------------------------------------------
// ask_div
// Pipelined restoring divider, one quotient bit a stage, giving a rounded
// and saturated wheel rate.
// ----------------------------------------------------------------------------
module ask_div import ask_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [NUMW-1:0]   i_num,
    input  logic signed [DENW-1:0]   i_den,
    output logic signed [RATE_W-1:0] o_rate
);

    localparam int RW   = NUMW + 1;
    localparam int DW2  = DENW + 1;
    localparam int CMPW = DW2 + QBITS;
    localparam logic [QBITS-1:0] POS_LIM = QBITS'((1 << (RATE_W - 1)) - 1);
    localparam logic [QBITS-1:0] NEG_LIM = QBITS'(1 << (RATE_W - 1));
    localparam logic signed [RATE_W-1:0] RATE_MAX = RATE_W'((1 << (RATE_W - 1)) - 1);
    localparam logic signed [RATE_W-1:0] RATE_MIN = RATE_W'(1 << (RATE_W - 1));

    typedef struct packed {
        logic [RW-1:0]    rem;
        logic [DW2-1:0]   d;
        logic [QBITS-1:0] q;
        logic             sat;
        logic             neg;
        logic             nneg;
        logic             nzero;
        logic             dzero;
    } t_ds;

    logic [NUMW-1:0] r_un;
    logic [DENW-1:0] r_ud;
    logic            r_neg, r_nneg, r_nzero, r_dzero;
    logic [RW-1:0]   n_n2;
    logic [DW2-1:0]  n_d2;
    t_ds             r_q;
    t_ds             fin;
    logic signed [RATE_W-1:0] n_rate;
    logic signed [RATE_W-1:0] r_rate;

    wire t_ds w_st [QBITS+1];

    always_comb begin
        n_n2 = (RW'(r_un) << 1) + RW'(r_ud);
        n_d2 = DW2'(r_ud) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_un    <= i_num[NUMW-1] ? NUMW'(-i_num) : NUMW'(i_num);
            r_ud    <= i_den[DENW-1] ? DENW'(-i_den) : DENW'(i_den);
            r_neg   <= i_num[NUMW-1] ^ i_den[DENW-1];
            r_nneg  <= i_num[NUMW-1];
            r_nzero <= (i_num == '0);
            r_dzero <= (i_den == '0);

            r_q.rem   <= n_n2;
            r_q.d     <= n_d2;
            r_q.q     <= '0;
            // quotient at or above 2^QBITS always saturates
            r_q.sat   <= CMPW'(n_n2) >= (CMPW'(n_d2) << QBITS);
            r_q.neg   <= r_neg;
            r_q.nneg  <= r_nneg;
            r_q.nzero <= r_nzero;
            r_q.dzero <= r_dzero;
        end
    end

    assign w_st[0] = r_q;

    for (genvar g = 0; g < QBITS; g++) begin : g_step
        localparam int B = QBITS - 1 - g;
        logic [CMPW-1:0] d_shift;
        t_ds             n_st;
        t_ds             r_st;
        assign d_shift = CMPW'(w_st[g].d) << B;
        always_comb begin
            n_st = w_st[g];
            if (CMPW'(w_st[g].rem) >= d_shift) begin
                n_st.rem  = RW'(CMPW'(w_st[g].rem) - d_shift);
                n_st.q[B] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st <= n_st;
            end
        end
        assign w_st[g+1] = r_st;
    end

    assign fin = w_st[QBITS];

    always_comb begin
        if (fin.dzero) begin
            n_rate = fin.nzero ? '0 : (fin.nneg ? RATE_MIN : RATE_MAX);
        end else if (fin.neg) begin
            n_rate = (fin.sat || fin.q > NEG_LIM) ? RATE_MIN
                                                  : RATE_W'(QBITS'(0) - fin.q);
        end else begin
            n_rate = (fin.sat || fin.q > POS_LIM) ? RATE_MAX : RATE_W'(fin.q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rate <= n_rate;
        end
    end

    assign o_rate = r_rate;

endmodule

/* hdl/ask_back.sv */
// ----------------------------------------------------------------------------
// ask_back
// Executes queued commands: two arctangent lanes and two divider lanes
// that advance together, ending in the output register.
// ----------------------------------------------------------------------------
module ask_back import ask_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    output logic                     o_pop,
    input  t_cmd                     i_cmd,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [ANG_W-1:0]  o_left_angle,
    output logic signed [ANG_W-1:0]  o_right_angle,
    output logic signed [RATE_W-1:0] o_left_rate,
    output logic signed [RATE_W-1:0] o_right_rate
);

    localparam int ANG_DLY = DIV_LAT - COR_LAT;

    logic               en;
    logic [DIV_LAT-1:0] r_v;
    logic signed [ANG_W-1:0] ang_l, ang_r;
    logic signed [ANG_W-1:0] r_angl [ANG_DLY];
    logic signed [ANG_W-1:0] r_angr [ANG_DLY];

    // the last stage is the output register
    assign en      = !r_v[DIV_LAT-1] || i_ready;
    assign o_pop   = en && !i_q_empty;
    assign o_valid = r_v[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[DIV_LAT-2:0], o_pop};
        end
    end

    ask_cordic u_cordic_l (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_force_zero (i_cmd.straight),
        .i_y          (i_cmd.y),
        .i_x          (i_cmd.xl),
        .o_angle      (ang_l)
    );

    ask_cordic u_cordic_r (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_force_zero (i_cmd.straight),
        .i_y          (i_cmd.y),
        .i_x          (i_cmd.xr),
        .o_angle      (ang_r)
    );

    ask_div u_div_l (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_cmd.numl),
        .i_den  (i_cmd.den),
        .o_rate (o_left_rate)
    );

    ask_div u_div_r (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_cmd.numr),
        .i_den  (i_cmd.den),
        .o_rate (o_right_rate)
    );

    // line up the angles with the longer divider pipe
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_angl[0] <= ang_l;
            r_angr[0] <= ang_r;
            for (int i = 1; i < ANG_DLY; i++) begin
                r_angl[i] <= r_angl[i-1];
                r_angr[i] <= r_angr[i-1];
            end
        end
    end

    assign o_left_angle  = r_angl[ANG_DLY-1];
    assign o_right_angle = r_angr[ANG_DLY-1];

endmodule

/* tb/ask_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ask_checker
// Watches the command, result and register channels of the steering block,
// predicts each result from the current geometry and compares field by field.
// ----------------------------------------------------------------------------
module ask_checker import ask_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [79:0]          m_axis_tdata,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_r;
        logic signed [RATE_W-1:0] rate_l;
        logic signed [ANG_W-1:0]  ang_r;
        logic signed [ANG_W-1:0]  ang_l;
    } t_wheels;

    t_geom   geom;
    t_wheels wheel_q[$];

    assign o_pending = wheel_q.size();

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vector_atan(longint unsigned y, longint unsigned x);
        longint unsigned m;
        longint xs, ys, z, dx, dy, r;
        m = (x > y) ? x : y;
        z = 0;
        if (m == 0) return 0;
        while (m < 64'd1 << 40) begin
            x = x << 1; y = y << 1; m = m << 1;
        end
        xs = x; ys = y;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr_floor(ys, i);
            dy = shr_floor(xs, i);
            if (ys > 0) begin
                xs += dx; ys -= dy; z += longint'(atan_step(i[STEP_IW-1:0]));
            end else begin
                xs -= dx; ys += dy; z -= longint'(atan_step(i[STEP_IW-1:0]));
            end
        end
        if (z < 0) return 0;
        r = (z + 64) >>> 7;
        return (r > 12868) ? 12868 : r;
    endfunction

    function automatic longint wheel_angle(longint unsigned y, longint x);
        if (x == 0) return 12868;
        if (x > 0) return vector_atan(y, x);
        return -vector_atan(y, -x);
    endfunction

    function automatic longint rate_div(longint n, longint d);
        longint unsigned un, ud, q;
        bit neg;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        neg = (n < 0) != (d < 0);
        if (ud == 0) begin
            if (un == 0) return 0;
            return (n < 0) ? -8388608 : 8388607;
        end
        q = (2 * un + ud) / (2 * ud);
        if (neg) return (q > 8388608) ? -8388608 : -longint'(q);
        return (q > 8388607) ? 8388607 : longint'(q);
    endfunction

    function automatic t_wheels wheels_for(logic [15:0] spd_in, logic [15:0] yaw_in);
        longint s, w, as, aw, lb, tr, trk, kp, lim2, rn, rd, al, ar, rl, rr;
        longint unsigned y;
        bit pos;
        t_wheels o;
        s = longint'($signed(spd_in)); w = longint'($signed(yaw_in));
        as = (s < 0) ? -s : s; aw = (w < 0) ? -w : w;
        lb = longint'(geom.axle_base); tr = longint'(geom.tyre_radius);
        trk = longint'(geom.wheel_track); kp = longint'(geom.kingpin_span);
        al = 0; ar = 0;
        if (s == 0 || aw * lb * 1000000 < as * 16384) begin
            rl = rate_div(s * 1024, tr); rr = rl;
        end else begin
            pos = (s < 0) == (w < 0);
            lim2 = 2 * longint'(geom.min_turn_radius) + trk;
            if (aw * lim2 > as * 32768) begin
                rd = 2; rn = pos ? lim2 : -lim2;
            end else begin
                rd = aw; rn = pos ? 16384 * as : -16384 * as;
            end
            y = 2 * lb * rd;
            al = wheel_angle(y, 2 * rn - kp * rd);
            ar = wheel_angle(y, 2 * rn + kp * rd);
            if (rn == 0) begin
                rl = rate_div(s * 1024, tr); rr = rl;
            end else begin
                rl = rate_div(s * 1024 * (2 * rn - trk * rd), 2 * rn * tr);
                rr = rate_div(s * 1024 * (2 * rn + trk * rd), 2 * rn * tr);
            end
        end
        o.ang_l = al[ANG_W-1:0]; o.ang_r = ar[ANG_W-1:0];
        o.rate_l = rl[RATE_W-1:0]; o.rate_r = rr[RATE_W-1:0];
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        t_wheels got, want;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            geom <= '{axle_base: 16'd2560, min_turn_radius: 16'd5120,
                      wheel_track: 16'd1536, kingpin_span: 16'd1229,
                      tyre_radius: 16'd307};
            wheel_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    REG_AXLE_BASE:       geom.axle_base       <= i_cfg_data;
                    REG_MIN_TURN_RADIUS: geom.min_turn_radius <= i_cfg_data;
                    REG_WHEEL_TRACK:     geom.wheel_track     <= i_cfg_data;
                    REG_KINGPIN_SPAN:    geom.kingpin_span    <= i_cfg_data;
                    REG_TYRE_RADIUS:     geom.tyre_radius     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                wheel_q.push_back(wheels_for(s_axis_tdata[15:0], s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[77:0];
                if (wheel_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_axis_tdata);
                    bad = bad + 1;
                end else begin
                    want = wheel_q.pop_front();
                    if (got.ang_l !== want.ang_l) begin
                        $error("left_steer_angle expected %0d got %0d", want.ang_l, got.ang_l);
                        bad = bad + 1;
                    end
                    if (got.ang_r !== want.ang_r) begin
                        $error("right_steer_angle expected %0d got %0d", want.ang_r, got.ang_r);
                        bad = bad + 1;
                    end
                    if (got.rate_l !== want.rate_l) begin
                        $error("left_wheel_rate expected %0d got %0d", want.rate_l, got.rate_l);
                        bad = bad + 1;
                    end
                    if (got.rate_r !== want.rate_r) begin
                        $error("right_wheel_rate expected %0d got %0d", want.rate_r, got.rate_r);
                        bad = bad + 1;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives speed and yaw-rate commands through several geometry settings with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import ask_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;  // forward_speed, yaw_rate
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [79:0]          m_axis_tdata;       // left/right angle, left/right rate
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]     i_cfg_data = '0;
    int                   err_cnt;
    int                   pending;
    bit                   calm = 1'b0;

    always #5 i_clk = ~i_clk;

    ackermann_steering_kinematics DUT (.*);

    ask_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_valid,
        .o_cfg_ready, .i_cfg_index, .i_cfg_data, .o_errors(err_cnt), .o_pending(pending)
    );

    // receiver stalls in bursts
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_cmd(logic [15:0] spd, logic [15:0] yaw);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yaw, spd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_geom(logic [15:0] lb, logic [15:0] mr, logic [15:0] trk,
                            logic [15:0] kp, logic [15:0] tr);
        write_reg(REG_AXLE_BASE, lb);
        write_reg(REG_MIN_TURN_RADIUS, mr);
        write_reg(REG_WHEEL_TRACK, trk);
        write_reg(REG_KINGPIN_SPAN, kp);
        write_reg(REG_TYRE_RADIUS, tr);
    endtask

    task automatic random_cmds(int cnt);
        logic [15:0] spd, yaw;
        for (int k = 0; k < cnt; k++) begin
            case ($urandom_range(0, 5))
                0: begin spd = 16'($urandom); yaw = 16'($urandom); end
                1: begin spd = 16'($urandom_range(0, 600) - 300); yaw = 16'($urandom); end
                2: begin spd = 16'($urandom); yaw = 16'($urandom_range(0, 8) - 4); end
                3: begin spd = 16'(int'($urandom_range(0, 4000)) - 2000);
                         yaw = 16'(int'($urandom_range(0, 4000)) - 2000); end
                4: begin spd = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                         yaw = 16'($urandom); end
                default: begin spd = 16'($urandom); yaw = '0; end
            endcase
            send_cmd(spd, yaw);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, straight, clamped and tiny tangents
        send_cmd(16'h0000, 16'h0000);
        send_cmd(16'h0000, 16'h7fff);
        send_cmd(16'h7fff, 16'h0000);
        send_cmd(16'h8000, 16'h0000);
        send_cmd(16'h7fff, 16'h7fff);
        send_cmd(16'h8000, 16'h8000);
        send_cmd(16'h7fff, 16'h8000);
        send_cmd(16'h8000, 16'h7fff);
        send_cmd(16'h7fff, 16'h0001);
        send_cmd(16'h0001, 16'h7fff);
        send_cmd(16'hffff, 16'h0001);
        send_cmd(16'h0100, 16'h0200);
        send_cmd(16'hff00, 16'hfe00);
        send_cmd(16'h0400, 16'h0010);
        send_cmd(16'hffff, 16'hffff);
        drain();

        // zero turn radius and wheel track, unit tyre radius, with kingpins collapsing
        set_geom(16'd2560, 16'd0, 16'd0, 16'd0, 16'd1);
        send_cmd(16'h0100, 16'h7fff);
        send_cmd(16'h8000, 16'h7fff);
        send_cmd(16'h7fff, 16'h0001);
        random_cmds(60);
        drain();

        set_geom(16'd1, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        random_cmds(100);
        drain();

        set_geom(16'd65535, 16'd0, 16'd65535, 16'd0, 16'd1);
        random_cmds(100);
        drain();

        set_geom(16'd3000, 16'd200, 16'd800, 16'd65535, 16'd200);
        random_cmds(100);
        drain();

        set_geom(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom_range(1, 65535)));
        random_cmds(130);
        drain();

        set_geom(16'd2560, 16'd5120, 16'd1536, 16'd1229, 16'd307);
        random_cmds(80);
        calm = 1'b1;
        random_cmds(80);
        drain();

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
